// ===== design/idsa_pkg.sv =====
// ----------------------------------------------------------------------------
// idsa_pkg
// Shared types, op codes, status codes and defaults for the data stack ALU.
// ----------------------------------------------------------------------------
package idsa_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_WORD_BITS   = 32;
  localparam int SCALE_SHIFT     = 2;   // scale_index multiplies the top by 4

  localparam int OP_BITS     = 5;
  localparam int STATUS_BITS = 2;
  localparam int TOP_BITS    = 32;

  localparam logic [OP_BITS-1:0] OP_PUSH  = 5'd0;
  localparam logic [OP_BITS-1:0] OP_ADD   = 5'd1;
  localparam logic [OP_BITS-1:0] OP_SUB   = 5'd2;
  localparam logic [OP_BITS-1:0] OP_MUL   = 5'd3;
  localparam logic [OP_BITS-1:0] OP_UDIV  = 5'd4;
  localparam logic [OP_BITS-1:0] OP_UMOD  = 5'd5;
  localparam logic [OP_BITS-1:0] OP_NEG   = 5'd6;
  localparam logic [OP_BITS-1:0] OP_OR    = 5'd7;
  localparam logic [OP_BITS-1:0] OP_AND   = 5'd8;
  localparam logic [OP_BITS-1:0] OP_NOT   = 5'd9;
  localparam logic [OP_BITS-1:0] OP_GT    = 5'd10;
  localparam logic [OP_BITS-1:0] OP_LT    = 5'd11;
  localparam logic [OP_BITS-1:0] OP_EQ    = 5'd12;
  localparam logic [OP_BITS-1:0] OP_ROT   = 5'd13;
  localparam logic [OP_BITS-1:0] OP_DUP   = 5'd14;
  localparam logic [OP_BITS-1:0] OP_SWAP  = 5'd15;
  localparam logic [OP_BITS-1:0] OP_DROP  = 5'd16;
  localparam logic [OP_BITS-1:0] OP_PICK  = 5'd17;
  localparam logic [OP_BITS-1:0] OP_SCALE = 5'd18;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_DIVZ  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_ROT  = 5'b00100,
    S_PICK = 5'b01000,
    S_MD   = 5'b10000
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  // Number of stack words an op needs on the stack before it can run.
  function automatic logic [1:0] op_need(input logic [OP_BITS-1:0] op);
    logic [1:0] n;
    n = 2'd0;
    if (op inside {[OP_ADD:OP_UMOD], OP_OR, OP_AND, [OP_GT:OP_EQ], OP_SWAP, OP_PICK,
                   OP_SCALE}) begin
      n = 2'd2;
    end else if (op inside {OP_NEG, OP_NOT, OP_DUP, OP_DROP}) begin
      n = 2'd1;
    end else if (op == OP_ROT) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

// ===== design/integer_data_stack_alu_top.sv =====
// ----------------------------------------------------------------------------
// integer_data_stack_alu_top
// Data stack ALU: one stack-language operation per request.
// ----------------------------------------------------------------------------
// Each request carries an op and a literal and returns one result with the
// new top of stack, the depth and a status. The top word lives in a register;
// the words below it live in a synchronous memory with one write and one
// registered read port. Most ops accept and read the second word, then
// execute and commit; rot and pick add a state for a second memory read.
// mul, udiv and umod go through a shared bit-serial unit. A new request is
// accepted while the previous result waits on out_stall; the block then
// holds at commit until the output slot frees. Errors (underflow, overflow,
// divide by zero) leave the stack as it was, except that pick keeps its
// index popped when it is too deep.
// ----------------------------------------------------------------------------
module integer_data_stack_alu_top #(
  parameter int STACK_DEPTH = idsa_pkg::DEF_STACK_DEPTH,
  parameter int WORD_BITS   = idsa_pkg::DEF_WORD_BITS,
  parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [idsa_pkg::OP_BITS-1:0]    op,
  input  logic [31:0]                     literal,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [idsa_pkg::TOP_BITS-1:0]   top_value,
  output logic [CW-1:0]                   stack_count,
  output logic [idsa_pkg::STATUS_BITS-1:0] status
);
  import idsa_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int W  = WORD_BITS;

  state_t               state, state_next;
  logic [OP_BITS-1:0]   op_q;
  logic [W-1:0]         lit_q;
  logic [CW-1:0]        sp, sp_next;
  logic [W-1:0]         top, top_next;
  logic [W-1:0]         a_hold, a_hold_next;

  logic                 accept;
  logic                 can_load;
  logic                 load;
  logic [STATUS_BITS-1:0] st;

  logic [CW-1:0]        sp_m1, sp_m2, sp_m3;
  logic [W-1:0]         a, b;
  logic                 under;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [W-1:0]         wr_data, rd_data;

  md_req_t              md_req;
  logic                 md_done;
  logic [W-1:0]         md_qp, md_rem;

  idsa_stack_mem #(
    .DEPTH     (STACK_DEPTH),
    .WORD_BITS (W),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // operands are sampled by the unit on the start cycle, while the second
  // word still sits on the read port
  idsa_muldiv #(
    .WORD_BITS (W)
  ) u_md (
    .clk      (clk),
    .rst      (rst),
    .req      (md_req),
    .a        (a),
    .b        (top),
    .done     (md_done),
    .quo_prod (md_qp),
    .rem      (md_rem)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;

  assign sp_m1 = sp - CW'(1);
  assign sp_m2 = sp - CW'(2);
  assign sp_m3 = sp - CW'(3);
  assign a     = rd_data;   // second word, read at accept
  assign b     = top;
  assign under = (op_q <= OP_SCALE) && (sp < CW'(op_need(op_q)));

  always_comb begin
    state_next   = state;
    sp_next      = sp;
    top_next     = top;
    a_hold_next  = a_hold;
    load         = 1'b0;
    st           = ST_OK;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = top;
    rd_en        = 1'b0;
    rd_addr      = '0;
    md_req       = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          // fetch the second word for whatever op comes next
          rd_en      = 1'b1;
          rd_addr    = sp_m2[AW-1:0];
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (can_load) begin
          if (under) begin
            st   = ST_UNDER;
            load = 1'b1;
          end else begin
            case (op_q)
              OP_PUSH, OP_DUP: begin
                if (sp == CW'(STACK_DEPTH)) begin
                  st = ST_OVER;
                end else begin
                  // spill the old top below the new one
                  wr_en    = (sp != '0);
                  wr_addr  = sp_m1[AW-1:0];
                  top_next = (op_q == OP_PUSH) ? lit_q : top;
                  sp_next  = sp + CW'(1);
                end
                load = 1'b1;
              end
              OP_ADD:   begin top_next = a + b;  sp_next = sp_m1; load = 1'b1; end
              OP_SUB:   begin top_next = a - b;  sp_next = sp_m1; load = 1'b1; end
              OP_OR:    begin top_next = a | b;  sp_next = sp_m1; load = 1'b1; end
              OP_AND:   begin top_next = a & b;  sp_next = sp_m1; load = 1'b1; end
              OP_GT: begin
                top_next = W'($signed(a) > $signed(b));
                sp_next  = sp_m1;
                load     = 1'b1;
              end
              OP_LT: begin
                top_next = W'($signed(a) < $signed(b));
                sp_next  = sp_m1;
                load     = 1'b1;
              end
              OP_EQ:    begin top_next = W'(a == b); sp_next = sp_m1; load = 1'b1; end
              OP_SCALE: begin
                top_next = a + (b << SCALE_SHIFT);
                sp_next  = sp_m1;
                load     = 1'b1;
              end
              OP_NEG:   begin top_next = '0 - b;        load = 1'b1; end
              OP_NOT:   begin top_next = W'(b == '0);   load = 1'b1; end
              OP_MUL, OP_UDIV, OP_UMOD: begin
                if (op_q != OP_MUL && b == '0) begin
                  st   = ST_DIVZ;
                  load = 1'b1;
                end else begin
                  md_req.start  = 1'b1;
                  md_req.is_div = (op_q != OP_MUL);
                  state_next    = S_MD;
                end
              end
              OP_ROT: begin
                // second slot takes the old top, then fetch the third word
                wr_en       = 1'b1;
                wr_addr     = sp_m2[AW-1:0];
                rd_en       = 1'b1;
                rd_addr     = sp_m3[AW-1:0];
                a_hold_next = a;
                state_next  = S_ROT;
              end
              OP_SWAP: begin
                wr_en    = 1'b1;
                wr_addr  = sp_m2[AW-1:0];
                top_next = a;
                load     = 1'b1;
              end
              OP_DROP: begin
                top_next = a;
                sp_next  = sp_m1;
                load     = 1'b1;
              end
              OP_PICK: begin
                if (b >= W'(sp_m1)) begin
                  // index stays consumed
                  st       = ST_UNDER;
                  top_next = a;
                  sp_next  = sp_m1;
                  load     = 1'b1;
                end else begin
                  rd_en      = 1'b1;
                  rd_addr    = sp_m2[AW-1:0] - b[AW-1:0];
                  state_next = S_PICK;
                end
              end
              default: begin
                load = 1'b1;
              end
            endcase
          end
        end
      end

      S_ROT: begin
        if (can_load) begin
          wr_en    = 1'b1;
          wr_addr  = sp_m3[AW-1:0];
          wr_data  = a_hold;
          top_next = rd_data;
          load     = 1'b1;
        end
      end

      S_PICK: begin
        if (can_load) begin
          top_next = rd_data;
          load     = 1'b1;
        end
      end

      S_MD: begin
        if (md_done && can_load) begin
          top_next = (op_q == OP_UMOD) ? md_rem : md_qp;
          sp_next  = sp_m1;
          load     = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (load) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top    <= top_next;
    a_hold <= a_hold_next;
    if (accept) begin
      op_q  <= op;
      lit_q <= W'(literal);
    end
    if (load) begin
      top_value   <= (sp_next == '0) ? '0 : TOP_BITS'(top_next);
      stack_count <= sp_next;
      status      <= st;
    end
  end

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted request did not reach execute");

  a_sp_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(sp))
    else $error("stack pointer moved without a commit");

  a_divz_op: assert property (@(posedge clk) disable iff (rst)
    (load && st == ST_DIVZ) |-> (op_q == OP_UDIV || op_q == OP_UMOD))
    else $error("divide by zero on a non-divide op");

  a_md_commit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MD && load) |-> md_done)
    else $error("commit before multiply/divide finished");
`endif

endmodule

// ===== design/idsa_stack_mem.sv =====
// ----------------------------------------------------------------------------
// idsa_stack_mem
// Stack word storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module idsa_stack_mem #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/idsa_muldiv.sv =====
// ----------------------------------------------------------------------------
// idsa_muldiv
// Shared bit-serial unit: shift-add multiply and restoring unsigned divide.
// ----------------------------------------------------------------------------
module idsa_muldiv #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  idsa_pkg::md_req_t    req,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic                 done,
  output logic [WORD_BITS-1:0] quo_prod,
  output logic [WORD_BITS-1:0] rem
);
  import idsa_pkg::*;

  localparam int CNTW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] x;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] divisor;
  logic                 is_div;
  logic                 running;
  logic [CNTW-1:0]      cnt;

  logic [WORD_BITS:0]   shifted;
  logic                 fits;
  logic [WORD_BITS:0]   diff;

  always_comb begin
    shifted = {acc, x[WORD_BITS-1]};
    fits    = (shifted >= {1'b0, divisor});
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (req.start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= CNTW'(WORD_BITS);
    end else if (running) begin
      cnt <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x       <= a;
      acc     <= '0;
      divisor <= b;
      is_div  <= req.is_div;
    end else if (running) begin
      if (is_div) begin
        acc <= fits ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
        x   <= {x[WORD_BITS-2:0], fits};
      end else begin
        acc <= (acc << 1) + (x[WORD_BITS-1] ? divisor : '0);
        x   <= x << 1;
      end
    end
  end

  assign quo_prod = is_div ? x : acc;
  assign rem      = acc;

endmodule

// ===== verif/integer_data_stack_alu_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_data_stack_alu_top_test
// Self-checking bench for the data stack ALU.
// ----------------------------------------------------------------------------
// An initial block fills a queue of requests: a directed opening that walks
// most ops, the underflow, overflow, divide by zero and deep pick cases, then
// random programs. A clocked driver feeds the queue to the block with random
// gaps. A stack model predicts the result of every accepted request, and a
// clocked monitor checks each result against the oldest prediction.
// ----------------------------------------------------------------------------
module integer_data_stack_alu_top_test;
  import idsa_pkg::*;

  localparam int DEPTH = DEF_STACK_DEPTH;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_OPS = 1700;
  localparam logic [OP_BITS-1:0] OP_UNUSED_LO = 5'd19;
  localparam logic [OP_BITS-1:0] OP_UNUSED_HI = 5'd31;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [31:0] literal;
  } stack_req_t;

  typedef struct packed {
    logic [31:0] top;
    logic [CW-1:0] count;
    logic [STATUS_BITS-1:0] status;
  } stack_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_BITS-1:0] op = '0;
  logic [31:0] literal = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] top_value;
  logic [CW-1:0] stack_count;
  logic [STATUS_BITS-1:0] status;

  stack_req_t pending_reqs[$];
  stack_rsp_t expected_rsps[$];
  logic [31:0] model_words[DEPTH];
  int model_count;
  int mismatches;
  int idle_cycles;
  int gap_left;
  int stall_left;
  int sent_count;
  int accepted_count;
  bit hold_for_drain;

  integer_data_stack_alu_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .literal(literal),
    .out_valid(out_valid), .out_stall(out_stall),
    .top_value(top_value), .stack_count(stack_count), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one, and sometimes none.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Advance the stack model by one request and return the predicted result.
  function automatic stack_rsp_t apply_stack_op(stack_req_t req);
    stack_rsp_t rsp;
    logic [1:0] need;
    logic [31:0] a, b, r;
    int c;
    c = model_count;
    rsp.status = ST_OK;
    a = '0;
    b = '0;
    r = '0;
    need = 2'd0;
    case (req.op)
      OP_ADD, OP_SUB, OP_MUL, OP_UDIV, OP_UMOD, OP_OR, OP_AND, OP_GT, OP_LT,
      OP_EQ, OP_SWAP, OP_PICK, OP_SCALE: need = 2'd2;
      OP_NEG, OP_NOT, OP_DUP, OP_DROP: need = 2'd1;
      OP_ROT: need = 2'd3;
      default: need = 2'd0;
    endcase
    if (c < need) begin
      rsp.status = ST_UNDER;
    end else begin
      if (need >= 1) b = model_words[c-1];
      if (need >= 2) a = model_words[c-2];
      case (req.op)
        OP_PUSH: begin
          if (c >= DEPTH) rsp.status = ST_OVER;
          else begin
            model_words[c] = req.literal;
            model_count = c + 1;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_UDIV, OP_UMOD, OP_OR, OP_AND, OP_GT, OP_LT,
        OP_EQ, OP_SCALE: begin
          if ((req.op == OP_UDIV || req.op == OP_UMOD) && b == 0) begin
            rsp.status = ST_DIVZ;
          end else begin
            case (req.op)
              OP_ADD: r = a + b;
              OP_SUB: r = a - b;
              OP_MUL: r = a * b;
              OP_UDIV: r = a / b;
              OP_UMOD: r = a % b;
              OP_OR: r = a | b;
              OP_AND: r = a & b;
              OP_GT: r = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
              OP_LT: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
              OP_EQ: r = (a == b) ? 32'd1 : 32'd0;
              default: r = a + (b << 2);
            endcase
            model_words[c-2] = r;
            model_count = c - 1;
          end
        end
        OP_NEG: model_words[c-1] = -b;
        OP_NOT: model_words[c-1] = (b == 0) ? 32'd1 : 32'd0;
        OP_ROT: begin
          r = model_words[c-3];
          model_words[c-3] = a;
          model_words[c-2] = b;
          model_words[c-1] = r;
        end
        OP_DUP: begin
          if (c >= DEPTH) rsp.status = ST_OVER;
          else begin
            model_words[c] = b;
            model_count = c + 1;
          end
        end
        OP_SWAP: begin
          model_words[c-1] = a;
          model_words[c-2] = b;
        end
        OP_DROP: model_count = c - 1;
        OP_PICK: begin
          // The index stays popped even when it reaches too deep.
          c = c - 1;
          model_count = c;
          if (b >= c) rsp.status = ST_UNDER;
          else begin
            model_words[c] = model_words[c-1-b];
            model_count = c + 1;
          end
        end
        default: ;
      endcase
    end
    rsp.count = CW'(model_count);
    rsp.top = (model_count > 0) ? model_words[model_count-1] : 32'd0;
    return rsp;
  endfunction

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return 32'h8000_0000;
    if (r == 3) return 32'h7FFF_FFFF;
    if (r == 4) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  task automatic queue_req(logic [OP_BITS-1:0] o, logic [31:0] lit);
    pending_reqs.push_back('{op: o, literal: lit});
  endtask

  // Driver: hold the request until it is accepted, then advance.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && sent_count != accepted_count) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_for_drain) begin
        in_valid <= 1'b1;
        op <= pending_reqs[0].op;
        literal <= pending_reqs[0].literal;
        void'(pending_reqs.pop_front());
        sent_count <= sent_count + 1;
        gap_left <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // Monitor: predict on request acceptance, check on result acceptance.
  always @(posedge clk) begin
    stack_rsp_t got, want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_rsps.push_back(apply_stack_op('{op: op, literal: literal}));
        accepted_count <= accepted_count + 1;
      end
      if (out_valid && !out_stall) begin
        got = '{top: top_value, count: stack_count, status: status};
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_rsps.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: top %h/%h count %0d/%0d status %0d/%0d (exp/act)",
                       want.top, got.top, want.count, got.count, want.status, got.status);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [OP_BITS-1:0] rop;
    int n;
    mismatches = 0;
    idle_cycles = 0;
    gap_left = 0;
    stall_left = 0;
    sent_count = 0;
    accepted_count = 0;
    hold_for_drain = 0;
    model_count = 0;
    // Directed: underflow on empty, most ops, divide by zero, deep pick.
    queue_req(OP_ADD, 32'd0);
    queue_req(OP_DROP, 32'd0);
    queue_req(OP_PUSH, 32'hFFFF_FFFF);
    queue_req(OP_PUSH, 32'd0);
    queue_req(OP_UDIV, 32'd0);
    queue_req(OP_UMOD, 32'd0);
    queue_req(OP_ROT, 32'd0);
    queue_req(OP_PUSH, 32'h8000_0000);
    queue_req(OP_ROT, 32'd0);
    queue_req(OP_GT, 32'd0);
    queue_req(OP_PUSH, 32'h7FFF_FFFF);
    queue_req(OP_LT, 32'd0);
    queue_req(OP_NEG, 32'd0);
    queue_req(OP_NOT, 32'd0);
    queue_req(OP_DUP, 32'd0);
    queue_req(OP_EQ, 32'd0);
    queue_req(OP_PUSH, 32'd9);
    queue_req(OP_PICK, 32'd0);
    queue_req(OP_PUSH, 32'd1);
    queue_req(OP_PICK, 32'd0);
    queue_req(OP_SWAP, 32'd0);
    queue_req(OP_SCALE, 32'd0);
    queue_req(OP_MUL, 32'd0);
    queue_req(OP_UNUSED_HI, 32'd0);
    queue_req(OP_UNUSED_LO, 32'd0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Fill to full and overflow, then pause until drained.
    for (int i = 0; i < DEPTH + 2; i++) queue_req(OP_PUSH, rand_word());
    queue_req(OP_DUP, 32'd0);
    wait (pending_reqs.size() == 0 && !in_valid);
    hold_for_drain = 1;
    wait (expected_rsps.size() == 0);
    @(negedge clk);
    hold_for_drain = 0;
    // Random programs: mostly legal ops, with noise.
    n = 0;
    while (n < RANDOM_OPS) begin
      n++;
      if ($urandom_range(0, 99) < 3)
        rop = OP_BITS'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else if ($urandom_range(0, 2) == 0) rop = OP_PUSH;
      else rop = OP_BITS'($urandom_range(OP_ADD, OP_SCALE));
      if (rop == OP_PICK && $urandom_range(0, 1)) queue_req(OP_PUSH, $urandom_range(0, 5));
      if (rop == OP_UDIV || rop == OP_UMOD) queue_req(OP_PUSH, rand_word());
      queue_req(rop, rand_word());
    end
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_rsps.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
